// ===== src/rv32c_instruction_expander_assert.svh =====
// Assertion macros shared by the RV32C expander RTL.
// Expects signals named clk and rst in the including scope.
`ifndef RV32C_INSTRUCTION_EXPANDER_ASSERT_SVH
`define RV32C_INSTRUCTION_EXPANDER_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define RVCX_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define RVCX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rvcx_pkg.sv =====
// Shared types, codes and encoders for the RV32C expander.
// No dependencies; every other RTL file refers to it by scoped names.
`default_nettype none

package rvcx_pkg;

  localparam int CINSTR_W = 16;
  localparam int INSTR_W  = 32;

  typedef logic [CINSTR_W-1:0] cinstr_t;
  typedef logic [INSTR_W-1:0]  instr_t;
  typedef logic [4:0]          reg_idx_t;
  typedef logic [2:0]          funct3_t;
  typedef logic [6:0]          opcode_t;

  typedef struct packed {
    instr_t expanded_instr;
    logic   illegal;
  } result_t;

  // Compressed quadrants (bits 1:0)
  localparam logic [1:0] QUAD_C0 = 2'b00;
  localparam logic [1:0] QUAD_C1 = 2'b01;
  localparam logic [1:0] QUAD_C2 = 2'b10;

  // Compressed funct3 (bits 15:13)
  localparam funct3_t C0_ADDI4SPN = 3'b000;
  localparam funct3_t C0_LW       = 3'b010;
  localparam funct3_t C0_SW       = 3'b110;
  localparam funct3_t C1_ADDI     = 3'b000;
  localparam funct3_t C1_JAL      = 3'b001;
  localparam funct3_t C1_LI       = 3'b010;
  localparam funct3_t C1_LUI      = 3'b011;
  localparam funct3_t C1_ARITH    = 3'b100;
  localparam funct3_t C1_J        = 3'b101;
  localparam funct3_t C1_BEQZ     = 3'b110;
  localparam funct3_t C1_BNEZ     = 3'b111;
  localparam funct3_t C2_SLLI     = 3'b000;
  localparam funct3_t C2_LWSP     = 3'b010;
  localparam funct3_t C2_JR_MV    = 3'b100;
  localparam funct3_t C2_SWSP     = 3'b110;

  // C1 arithmetic group selectors
  localparam logic [1:0] ARITH_SRLI = 2'b00;
  localparam logic [1:0] ARITH_SRAI = 2'b01;
  localparam logic [1:0] ARITH_ANDI = 2'b10;
  localparam logic [1:0] ARITH_REG  = 2'b11;
  localparam logic [1:0] REG_SUB    = 2'b00;
  localparam logic [1:0] REG_XOR    = 2'b01;
  localparam logic [1:0] REG_OR     = 2'b10;
  localparam logic [1:0] REG_AND    = 2'b11;

  // Base opcodes
  localparam opcode_t OP_IMM    = 7'b0010011;
  localparam opcode_t OP_LOAD   = 7'b0000011;
  localparam opcode_t OP_STORE  = 7'b0100011;
  localparam opcode_t OP_JAL    = 7'b1101111;
  localparam opcode_t OP_BRANCH = 7'b1100011;
  localparam opcode_t OP_LUI    = 7'b0110111;
  localparam opcode_t OP_REG    = 7'b0110011;
  localparam opcode_t OP_JALR   = 7'b1100111;
  localparam opcode_t OP_SYSTEM = 7'b1110011;

  // Base funct3 / funct7
  localparam funct3_t F3_ADD = 3'b000;
  localparam funct3_t F3_SLL = 3'b001;
  localparam funct3_t F3_W   = 3'b010;
  localparam funct3_t F3_XOR = 3'b100;
  localparam funct3_t F3_SR  = 3'b101;
  localparam funct3_t F3_OR  = 3'b110;
  localparam funct3_t F3_AND = 3'b111;
  localparam funct3_t F3_BEQ = 3'b000;
  localparam funct3_t F3_BNE = 3'b001;
  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  localparam reg_idx_t REG_ZERO = 5'd0;
  localparam reg_idx_t REG_RA   = 5'd1;
  localparam reg_idx_t REG_SP   = 5'd2;

  localparam logic [11:0] IMM_EBREAK = 12'h001;
  localparam instr_t      NOP_WORD   = 32'h0000_0013;

  function automatic instr_t enc_i(logic [11:0] imm, reg_idx_t rs1, funct3_t f3,
                                   reg_idx_t rd, opcode_t op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic instr_t enc_r(logic [6:0] f7, reg_idx_t rs2, reg_idx_t rs1,
                                   funct3_t f3, reg_idx_t rd, opcode_t op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic instr_t enc_s(logic [11:0] imm, reg_idx_t rs2, reg_idx_t rs1,
                                   funct3_t f3, opcode_t op);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], op};
  endfunction

  function automatic instr_t enc_b(logic [12:0] imm, reg_idx_t rs2, reg_idx_t rs1,
                                   funct3_t f3, opcode_t op);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], op};
  endfunction

  function automatic instr_t enc_j(logic [20:0] imm, reg_idx_t rd, opcode_t op);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, op};
  endfunction

endpackage

`default_nettype wire

// ===== src/rvcx_instr_if.sv =====
// Channel carrying one compressed instruction per transaction.
// Depends on rvcx_pkg for the payload width.
`default_nettype none

interface rvcx_instr_if;
  logic                  valid;
  logic                  ready;
  rvcx_pkg::cinstr_t     compressed_instr;

  modport source (output valid, output compressed_instr, input ready);
  modport sink   (input valid, input compressed_instr, output ready);
endinterface

`default_nettype wire

// ===== src/rvcx_result_if.sv =====
// Channel carrying one expanded instruction and its illegal flag per transaction.
// Depends on rvcx_pkg for the payload width.
`default_nettype none

interface rvcx_result_if;
  logic                  valid;
  logic                  ready;
  rvcx_pkg::instr_t      expanded_instr;
  logic                  illegal;

  modport source (output valid, output expanded_instr, output illegal, input ready);
  modport sink   (input valid, input expanded_instr, input illegal, output ready);
endinterface

`default_nettype wire

// ===== src/rvcx_in_stage.sv =====
// Input register: captures one compressed instruction per transaction.
// Depends on rvcx_pkg and rvcx_instr_if.
`default_nettype none

module rvcx_in_stage (
  input  wire logic         clk,
  input  wire logic         rst,
  rvcx_instr_if.sink        instr,
  input  wire logic         advance,
  output logic              valid,
  output rvcx_pkg::cinstr_t word
);

  assign instr.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (instr.ready) begin
      valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (instr.valid && instr.ready) begin
      word <= instr.compressed_instr;
    end
  end

endmodule

`default_nettype wire

// ===== src/rvcx_decode.sv =====
// Combinational RV32C to RV32I expansion of one registered instruction word.
// Depends on rvcx_pkg for codes, encoders and the result type.
`default_nettype none

module rvcx_decode (
  input  wire rvcx_pkg::cinstr_t word,
  output rvcx_pkg::result_t      result
);

  always_comb begin
    logic [1:0]           quad;
    rvcx_pkg::funct3_t    f3;
    rvcx_pkg::reg_idx_t   rd;
    rvcx_pkg::reg_idx_t   rs2;
    rvcx_pkg::reg_idx_t   rdp;
    rvcx_pkg::reg_idx_t   rs1p;
    logic [11:0]          ci;
    logic                 ci_zero;
    logic [9:0]           imm10;
    logic [6:0]           lo7;
    logic [7:0]           imm8;
    logic [20:0]          cj;
    logic [12:0]          cb;
    rvcx_pkg::instr_t     w;
    logic                 bad;

    quad    = word[1:0];
    f3      = word[15:13];
    rd      = word[11:7];
    rs2     = word[6:2];
    rdp     = {2'b01, word[4:2]};
    rs1p    = {2'b01, word[9:7]};
    ci      = {{6{word[12]}}, word[12], word[6:2]};
    ci_zero = !word[12] && (word[6:2] == 5'd0);
    lo7     = {word[5], word[12:10], word[6], 2'b00};
    cj      = {{10{word[12]}}, word[8], word[10:9], word[6], word[7], word[2],
               word[11], word[5:3], 1'b0};
    cb      = {{4{word[12]}}, word[12], word[6:5], word[2], word[11:10], word[4:3], 1'b0};
    imm10   = '0;
    imm8    = '0;
    w       = '0;
    bad     = 1'b0;

    case (quad)
      rvcx_pkg::QUAD_C0: begin
        case (f3)
          rvcx_pkg::C0_ADDI4SPN: begin
            imm10 = {word[10:7], word[12:11], word[5], word[6], 2'b00};
            bad   = (imm10 == 10'd0);
            w     = rvcx_pkg::enc_i({2'b00, imm10}, rvcx_pkg::REG_SP, rvcx_pkg::F3_ADD,
                                    rdp, rvcx_pkg::OP_IMM);
          end
          rvcx_pkg::C0_LW: begin
            w = rvcx_pkg::enc_i({5'd0, lo7}, rs1p, rvcx_pkg::F3_W, rdp, rvcx_pkg::OP_LOAD);
          end
          rvcx_pkg::C0_SW: begin
            w = rvcx_pkg::enc_s({5'd0, lo7}, rdp, rs1p, rvcx_pkg::F3_W, rvcx_pkg::OP_STORE);
          end
          default: bad = 1'b1;
        endcase
      end

      rvcx_pkg::QUAD_C1: begin
        case (f3)
          rvcx_pkg::C1_ADDI: begin
            w = (ci_zero || rd == rvcx_pkg::REG_ZERO) ? rvcx_pkg::NOP_WORD :
                rvcx_pkg::enc_i(ci, rd, rvcx_pkg::F3_ADD, rd, rvcx_pkg::OP_IMM);
          end
          rvcx_pkg::C1_JAL: begin
            w = rvcx_pkg::enc_j(cj, rvcx_pkg::REG_RA, rvcx_pkg::OP_JAL);
          end
          rvcx_pkg::C1_LI: begin
            w = (rd == rvcx_pkg::REG_ZERO) ? rvcx_pkg::NOP_WORD :
                rvcx_pkg::enc_i(ci, rvcx_pkg::REG_ZERO, rvcx_pkg::F3_ADD, rd,
                                rvcx_pkg::OP_IMM);
          end
          rvcx_pkg::C1_LUI: begin
            if (rd == rvcx_pkg::REG_SP) begin
              imm10 = {word[12], word[4:3], word[5], word[2], word[6], 4'd0};
              bad   = (imm10 == 10'd0);
              w     = rvcx_pkg::enc_i({{2{word[12]}}, imm10}, rvcx_pkg::REG_SP,
                                      rvcx_pkg::F3_ADD, rvcx_pkg::REG_SP, rvcx_pkg::OP_IMM);
            end else begin
              bad = ci_zero;
              w   = (rd == rvcx_pkg::REG_ZERO) ? rvcx_pkg::NOP_WORD :
                    {{14{word[12]}}, word[12], word[6:2], rd, rvcx_pkg::OP_LUI};
            end
          end
          rvcx_pkg::C1_ARITH: begin
            case (word[11:10]) inside
              rvcx_pkg::ARITH_SRLI, rvcx_pkg::ARITH_SRAI: begin
                bad = word[12] || (rs2 == 5'd0);
                w   = rvcx_pkg::enc_r(word[10] ? rvcx_pkg::F7_ALT : rvcx_pkg::F7_BASE, rs2,
                                      rs1p, rvcx_pkg::F3_SR, rs1p, rvcx_pkg::OP_IMM);
              end
              rvcx_pkg::ARITH_ANDI: begin
                w = rvcx_pkg::enc_i(ci, rs1p, rvcx_pkg::F3_AND, rs1p, rvcx_pkg::OP_IMM);
              end
              default: begin
                bad = word[12];
                case (word[6:5])
                  rvcx_pkg::REG_SUB: w = rvcx_pkg::enc_r(rvcx_pkg::F7_ALT, rdp, rs1p,
                                                         rvcx_pkg::F3_ADD, rs1p, rvcx_pkg::OP_REG);
                  rvcx_pkg::REG_XOR: w = rvcx_pkg::enc_r(rvcx_pkg::F7_BASE, rdp, rs1p,
                                                         rvcx_pkg::F3_XOR, rs1p, rvcx_pkg::OP_REG);
                  rvcx_pkg::REG_OR:  w = rvcx_pkg::enc_r(rvcx_pkg::F7_BASE, rdp, rs1p,
                                                         rvcx_pkg::F3_OR, rs1p, rvcx_pkg::OP_REG);
                  default:           w = rvcx_pkg::enc_r(rvcx_pkg::F7_BASE, rdp, rs1p,
                                                         rvcx_pkg::F3_AND, rs1p, rvcx_pkg::OP_REG);
                endcase
              end
            endcase
          end
          rvcx_pkg::C1_J: begin
            w = rvcx_pkg::enc_j(cj, rvcx_pkg::REG_ZERO, rvcx_pkg::OP_JAL);
          end
          rvcx_pkg::C1_BEQZ: begin
            w = rvcx_pkg::enc_b(cb, rvcx_pkg::REG_ZERO, rs1p, rvcx_pkg::F3_BEQ,
                                rvcx_pkg::OP_BRANCH);
          end
          default: begin
            w = rvcx_pkg::enc_b(cb, rvcx_pkg::REG_ZERO, rs1p, rvcx_pkg::F3_BNE,
                                rvcx_pkg::OP_BRANCH);
          end
        endcase
      end

      rvcx_pkg::QUAD_C2: begin
        case (f3)
          rvcx_pkg::C2_SLLI: begin
            bad = word[12] || (rs2 == 5'd0);
            w   = (rd == rvcx_pkg::REG_ZERO) ? rvcx_pkg::NOP_WORD :
                  rvcx_pkg::enc_r(rvcx_pkg::F7_BASE, rs2, rd, rvcx_pkg::F3_SLL, rd,
                                  rvcx_pkg::OP_IMM);
          end
          rvcx_pkg::C2_LWSP: begin
            bad  = (rd == rvcx_pkg::REG_ZERO);
            imm8 = {word[3:2], word[12], word[6:4], 2'b00};
            w    = rvcx_pkg::enc_i({4'd0, imm8}, rvcx_pkg::REG_SP, rvcx_pkg::F3_W, rd,
                                   rvcx_pkg::OP_LOAD);
          end
          rvcx_pkg::C2_JR_MV: begin
            if (rs2 == rvcx_pkg::REG_ZERO) begin
              if (!word[12]) begin
                // jr: rs1 of zero is reserved
                bad = (rd == rvcx_pkg::REG_ZERO);
                w   = rvcx_pkg::enc_i(12'd0, rd, rvcx_pkg::F3_ADD, rvcx_pkg::REG_ZERO,
                                      rvcx_pkg::OP_JALR);
              end else if (rd == rvcx_pkg::REG_ZERO) begin
                w = rvcx_pkg::enc_i(rvcx_pkg::IMM_EBREAK, rvcx_pkg::REG_ZERO,
                                    rvcx_pkg::F3_ADD, rvcx_pkg::REG_ZERO, rvcx_pkg::OP_SYSTEM);
              end else begin
                w = rvcx_pkg::enc_i(12'd0, rd, rvcx_pkg::F3_ADD, rvcx_pkg::REG_RA,
                                    rvcx_pkg::OP_JALR);
              end
            end else begin
              // mv adds to x0, add adds to rd
              w = (rd == rvcx_pkg::REG_ZERO) ? rvcx_pkg::NOP_WORD :
                  rvcx_pkg::enc_r(rvcx_pkg::F7_BASE, rs2,
                                  word[12] ? rd : rvcx_pkg::REG_ZERO,
                                  rvcx_pkg::F3_ADD, rd, rvcx_pkg::OP_REG);
            end
          end
          rvcx_pkg::C2_SWSP: begin
            imm8 = {word[8:7], word[12:9], 2'b00};
            w    = rvcx_pkg::enc_s({4'd0, imm8}, rs2, rvcx_pkg::REG_SP, rvcx_pkg::F3_W,
                                   rvcx_pkg::OP_STORE);
          end
          default: bad = 1'b1;
        endcase
      end

      default: bad = 1'b1;
    endcase

    result.expanded_instr = bad ? '0 : w;
    result.illegal        = bad;
  end

endmodule

`default_nettype wire

// ===== src/rvcx_out_stage.sv =====
// Result register: holds one expanded instruction until the sink takes it.
// Depends on rvcx_pkg and rvcx_result_if.
`default_nettype none

module rvcx_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              valid_in,
  input  wire rvcx_pkg::result_t data_in,
  output logic                   ready_out,
  rvcx_result_if.source          result
);

  logic              valid;
  rvcx_pkg::result_t data;

  assign ready_out             = !valid || result.ready;
  assign result.valid          = valid;
  assign result.expanded_instr = data.expanded_instr;
  assign result.illegal        = data.illegal;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_out) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_in && ready_out) begin
      data <= data_in;
    end
  end

endmodule

`default_nettype wire

// ===== src/rv32c_instruction_expander.sv =====
// RV32C instruction expander top level: input register, expansion logic, result register.
// Path: an input transaction lands in the input register, passes the expansion logic and
// lands in the result register; throughput 1 per cycle while the sink does not stall,
// with a single pass of expansion logic between the two registers.
// Reset (rst, synchronous, active high) empties both registers; nothing else is kept.
// Depends on rvcx_pkg, rvcx_instr_if, rvcx_result_if and the rvcx_* stages.
`default_nettype none

`include "rv32c_instruction_expander_assert.svh"

module rv32c_instruction_expander (
  input  wire logic     clk,
  input  wire logic     rst,
  rvcx_instr_if.sink    instr,
  rvcx_result_if.source result
);

  // Stage 1 holds the raw compressed word; it advances whenever the
  // result register has room or is being drained this cycle.
  logic              word_valid;
  rvcx_pkg::cinstr_t word;
  logic              out_ready;

  // Combinational rearrangement of the held word into the base encoding, with its illegal flag.
  rvcx_pkg::result_t expanded;

  rvcx_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .instr   (instr),
    .advance (out_ready),
    .valid   (word_valid),
    .word    (word)
  );

  rvcx_decode u_decode (
    .word   (word),
    .result (expanded)
  );

  // Stage 2 holds the finished transaction while the sink stalls, so a new
  // compressed word can still enter stage 1 behind it.
  rvcx_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (word_valid),
    .data_in   (expanded),
    .ready_out (out_ready),
    .result    (result)
  );

  // An illegal transaction never carries an expansion.
  `RVCX_ASSERT_SAME(a_illegal_zero, result.valid && result.illegal,
                    result.expanded_instr == '0, "illegal result carries nonzero word")
  // Every legal expansion is a 32-bit base encoding.
  `RVCX_ASSERT_SAME(a_legal_base, result.valid && !result.illegal,
                    result.expanded_instr[1:0] == 2'b11, "legal result is not a base encoding")
  // A held word that is stalled stays put.
  `RVCX_ASSERT_NEXT(a_hold_word, word_valid && !out_ready,
                    word_valid && $stable(word), "stage 1 word lost while stalled")
  // A word moving on lands in the result register.
  `RVCX_ASSERT_NEXT(a_advance, word_valid && out_ready,
                    result.valid, "stage 1 word dropped on advance")
  // An accepted transaction is held in stage 1 on the next cycle.
  `RVCX_ASSERT_NEXT(a_capture, instr.valid && instr.ready,
                    word_valid, "accepted transaction not captured")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking bench for the RV32C instruction expander: feeds compressed words,
// predicts each 32-bit expansion and illegal flag, and checks every result transaction.
// Depends on rvcx_pkg, rvcx_instr_if, rvcx_result_if and the expander RTL.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rvcx_pkg::*;

  localparam int CLK_PERIOD       = 10;
  localparam int RESET_CYCLES     = 6;
  localparam int RANDOM_PER_PHASE = 166;
  localparam int LONG_HOLD        = 300;
  // Pipeline is two registers deep; give it a few spare cycles after the last result.
  localparam int DRAIN_CYCLES     = 10;
  localparam int CYCLE_LIMIT      = 50000;

  // Bits 1:0 = 11 marks a full-width instruction, never a compressed one.
  localparam logic [1:0] QUAD_RSVD = 2'b11;

  // Base instruction layouts used to assemble the predicted word.
  typedef enum logic [2:0] {FMT_I, FMT_R, FMT_S, FMT_B, FMT_J, FMT_U} layout_t;

  logic clk = 1'b0;
  logic rst;

  rvcx_instr_if  instr_ch ();
  rvcx_result_if result_ch ();

  rv32c_instruction_expander dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_ch),
    .result (result_ch)
  );

  // Words waiting to be offered, and expansions waiting for their result transaction.
  cinstr_t pending_words[$];
  result_t expected_results[$];

  int mismatches    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_armed    = 1'b0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int cycle_count   = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predict the expansion of one compressed word. Gather the fields of the base
  // instruction first, then assemble them once according to the layout.
  function automatic result_t expand_rvc(cinstr_t c);
    logic [1:0]  quad;
    funct3_t     cf3;
    reg_idx_t    rd_f, rs2_f, rdp, rs1p;
    logic [31:0] ci, imm;
    logic [4:0]  shamt;
    layout_t     fmt;
    opcode_t     op;
    funct3_t     f3;
    reg_idx_t    rd, rs1, rs2;
    logic [6:0]  f7;
    logic        bad, nop;
    result_t     r;

    quad  = c[1:0];
    cf3   = c[15:13];
    rd_f  = c[11:7];
    rs2_f = c[6:2];
    rdp   = {2'b01, c[4:2]};
    rs1p  = {2'b01, c[9:7]};
    ci    = {{26{c[12]}}, c[12], c[6:2]};
    shamt = c[6:2];

    fmt = FMT_I;
    op  = OP_IMM;
    f3  = F3_ADD;
    rd  = REG_ZERO;
    rs1 = REG_ZERO;
    rs2 = REG_ZERO;
    f7  = F7_BASE;
    imm = '0;
    bad = 1'b0;
    nop = 1'b0;

    case (quad)
      QUAD_C0: begin
        case (cf3)
          C0_ADDI4SPN: begin
            // A zero immediate is reserved, the all-zero word among them.
            imm = {22'b0, c[10:7], c[12:11], c[5], c[6], 2'b00};
            bad = (imm == '0);
            rs1 = REG_SP;
            rd  = rdp;
          end
          C0_LW: begin
            imm = {25'b0, c[5], c[12:10], c[6], 2'b00};
            op  = OP_LOAD;
            f3  = F3_W;
            rs1 = rs1p;
            rd  = rdp;
          end
          C0_SW: begin
            imm = {25'b0, c[5], c[12:10], c[6], 2'b00};
            fmt = FMT_S;
            op  = OP_STORE;
            f3  = F3_W;
            rs1 = rs1p;
            rs2 = rdp;
          end
          default: bad = 1'b1;
        endcase
      end
      QUAD_C1: begin
        case (cf3)
          C1_ADDI: begin
            // Zero immediate or rd zero is a hint: collapse to the nop.
            nop = (ci == '0) || (rd_f == REG_ZERO);
            imm = ci;
            rs1 = rd_f;
            rd  = rd_f;
          end
          C1_JAL, C1_J: begin
            fmt = FMT_J;
            op  = OP_JAL;
            rd  = (cf3 == C1_JAL) ? REG_RA : REG_ZERO;
            imm = {{21{c[12]}}, c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0};
          end
          C1_LI: begin
            nop = (rd_f == REG_ZERO);
            imm = ci;
            rd  = rd_f;
          end
          C1_LUI: begin
            if (rd_f == REG_SP) begin
              // ADDI16SP: scaled by 16, zero is reserved.
              imm = {{23{c[12]}}, c[4:3], c[5], c[2], c[6], 4'b0000};
              bad = (imm == '0);
              rs1 = REG_SP;
              rd  = REG_SP;
            end else begin
              // The zero-immediate check wins over the rd-zero hint.
              bad = (ci == '0);
              nop = (rd_f == REG_ZERO);
              fmt = FMT_U;
              op  = OP_LUI;
              rd  = rd_f;
              imm = ci << 12;
            end
          end
          C1_ARITH: begin
            rs1 = rs1p;
            rd  = rs1p;
            case (c[11:10])
              ARITH_SRLI, ARITH_SRAI: begin
                // shamt[5] set or a zero shift is not legal on RV32.
                bad = c[12] || (shamt == '0);
                fmt = FMT_R;
                f3  = F3_SR;
                rs2 = shamt;
                f7  = (c[11:10] == ARITH_SRAI) ? F7_ALT : F7_BASE;
              end
              ARITH_ANDI: begin
                imm = ci;
                f3  = F3_AND;
              end
              default: begin
                // Bit 12 set is the RV64 word-op space or reserved.
                bad = c[12];
                fmt = FMT_R;
                op  = OP_REG;
                rs2 = rdp;
                case (c[6:5])
                  REG_SUB: begin
                    f3 = F3_ADD;
                    f7 = F7_ALT;
                  end
                  REG_XOR: f3 = F3_XOR;
                  REG_OR:  f3 = F3_OR;
                  default: f3 = F3_AND;
                endcase
              end
            endcase
          end
          default: begin
            fmt = FMT_B;
            op  = OP_BRANCH;
            rs1 = rs1p;
            f3  = (cf3 == C1_BEQZ) ? F3_BEQ : F3_BNE;
            imm = {{24{c[12]}}, c[6:5], c[2], c[11:10], c[4:3], 1'b0};
          end
        endcase
      end
      QUAD_C2: begin
        case (cf3)
          C2_SLLI: begin
            // Shift checks come before the rd-zero hint.
            bad = c[12] || (shamt == '0);
            nop = (rd_f == REG_ZERO);
            fmt = FMT_R;
            f3  = F3_SLL;
            rs2 = shamt;
            rs1 = rd_f;
            rd  = rd_f;
          end
          C2_LWSP: begin
            bad = (rd_f == REG_ZERO);
            imm = {24'b0, c[3:2], c[12], c[6:4], 2'b00};
            op  = OP_LOAD;
            f3  = F3_W;
            rs1 = REG_SP;
            rd  = rd_f;
          end
          C2_JR_MV: begin
            if (rs2_f == REG_ZERO) begin
              if (!c[12]) begin
                // C.JR through x0 is reserved.
                bad = (rd_f == REG_ZERO);
                op  = OP_JALR;
                rs1 = rd_f;
              end else if (rd_f == REG_ZERO) begin
                op  = OP_SYSTEM;
                imm = {20'b0, IMM_EBREAK};
              end else begin
                op  = OP_JALR;
                rs1 = rd_f;
                rd  = REG_RA;
              end
            end else begin
              // C.MV reads x0, C.ADD reads rd; rd zero is a hint for both.
              nop = (rd_f == REG_ZERO);
              fmt = FMT_R;
              op  = OP_REG;
              rs2 = rs2_f;
              rs1 = c[12] ? rd_f : REG_ZERO;
              rd  = rd_f;
            end
          end
          C2_SWSP: begin
            imm = {24'b0, c[8:7], c[12:9], 2'b00};
            fmt = FMT_S;
            op  = OP_STORE;
            f3  = F3_W;
            rs1 = REG_SP;
            rs2 = rs2_f;
          end
          default: bad = 1'b1;
        endcase
      end
      default: bad = 1'b1;
    endcase

    r.illegal = bad;
    if (bad) begin
      r.expanded_instr = '0;
    end else if (nop) begin
      r.expanded_instr = NOP_WORD;
    end else begin
      case (fmt)
        FMT_I:   r.expanded_instr = {imm[11:0], rs1, f3, rd, op};
        FMT_R:   r.expanded_instr = {f7, rs2, rs1, f3, rd, op};
        FMT_S:   r.expanded_instr = {imm[11:5], rs2, rs1, f3, imm[4:0], op};
        FMT_B:   r.expanded_instr = {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], op};
        FMT_J:   r.expanded_instr = {imm[20], imm[10:1], imm[11], imm[19:12], rd, op};
        default: r.expanded_instr = {imm[31:12], rd, op};
      endcase
    end
    return r;
  endfunction

  // Build a compressed word from funct3, bits 12:2 and the quadrant.
  function automatic cinstr_t compose(funct3_t f3, logic [10:0] body, logic [1:0] quad);
    return {f3, body, quad};
  endfunction

  // Mostly well-formed quadrants, with register fields leaning toward the values
  // that hit hints and reserved checks; the rest is raw noise including quadrant three.
  function automatic cinstr_t random_compressed();
    logic [1:0] quads[3] = '{QUAD_C0, QUAD_C1, QUAD_C2};
    cinstr_t    c;
    c = cinstr_t'($urandom);
    if ($urandom_range(99) < 85) begin
      c[1:0] = quads[$urandom_range(2)];
      case ($urandom_range(9))
        0: c[6:2]  = REG_ZERO;
        1: c[11:7] = REG_ZERO;
        2: c[11:7] = REG_SP;
        3: c[12]   = 1'b0;
        default: ;
      endcase
    end
    return c;
  endfunction

  // Sender: predict each accepted transaction, then advance to the next word or idle.
  // Hold valid and the word steady while the block stalls.
  always @(posedge clk) begin
    if (rst) begin
      instr_ch.valid            <= 1'b0;
      instr_ch.compressed_instr <= '0;
    end else begin
      if (instr_ch.valid && instr_ch.ready)
        expected_results.push_back(expand_rvc(instr_ch.compressed_instr));
      if (!instr_ch.valid || instr_ch.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          instr_ch.valid            <= 1'b1;
          instr_ch.compressed_instr <= pending_words.pop_front();
        end else begin
          instr_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random ready, plus one long hold-off once armed so the pipeline
  // backs up and the block has to stall its input side.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_left       <= 0;
      hold_done       <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_left       <= LONG_HOLD;
      hold_done       <= 1'b1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Checker: compare every result transaction against the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing pending: expanded_instr=%h illegal=%b",
               result_ch.expanded_instr, result_ch.illegal);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (result_ch.expanded_instr !== want.expanded_instr) begin
          $error("expanded_instr: expected %h, got %h",
                 want.expanded_instr, result_ch.expanded_instr);
          mismatches++;
        end
        if (result_ch.illegal !== want.illegal) begin
          $error("illegal: expected %b, got %b", want.illegal, result_ch.illegal);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst                       = 1'b1;
    instr_ch.valid            = 1'b0;
    instr_ch.compressed_instr = '0;
    result_ch.ready           = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed words: field extremes, every quadrant-0 funct3, and the hint and
    // reserved corners of quadrants 1 and 2.
    pending_words.push_back(compose(C0_ADDI4SPN, 11'h000, QUAD_C0));
    pending_words.push_back({14'h3FFF, QUAD_RSVD});
    for (int f = 0; f < 8; f++)
      pending_words.push_back(compose(funct3_t'(f), 11'($urandom), QUAD_C0));
    pending_words.push_back(compose(C1_ADDI, {1'b0, 5'd5, 5'd0}, QUAD_C1));
    pending_words.push_back(compose(C1_LI, {1'b1, REG_ZERO, 5'h1F}, QUAD_C1));
    pending_words.push_back(compose(C1_LUI, {1'b0, REG_SP, 5'd0}, QUAD_C1));
    pending_words.push_back(compose(C1_LUI, {1'b1, REG_SP, 5'h1F}, QUAD_C1));
    pending_words.push_back(compose(C1_LUI, {1'b0, REG_ZERO, 5'd0}, QUAD_C1));
    pending_words.push_back(compose(C1_LUI, {1'b1, REG_ZERO, 5'd1}, QUAD_C1));
    pending_words.push_back(compose(C1_ARITH, {1'b1, ARITH_SRAI, 3'd7, 5'd3}, QUAD_C1));
    pending_words.push_back(compose(C1_ARITH, {1'b0, ARITH_SRLI, 3'd0, 5'd0}, QUAD_C1));
    pending_words.push_back(compose(C1_ARITH, {1'b1, ARITH_REG, 3'd1, REG_OR, 3'd4},
                                    QUAD_C1));
    pending_words.push_back(compose(C1_JAL, 11'h7FF, QUAD_C1));
    pending_words.push_back(compose(C1_BEQZ, 11'h7FF, QUAD_C1));
    pending_words.push_back(compose(C2_SLLI, {1'b0, REG_ZERO, 5'd0}, QUAD_C2));
    pending_words.push_back(compose(C2_SLLI, {1'b0, REG_ZERO, 5'd31}, QUAD_C2));
    pending_words.push_back(compose(C2_LWSP, {1'b1, REG_ZERO, 5'h1F}, QUAD_C2));
    pending_words.push_back(compose(C2_JR_MV, {1'b0, REG_ZERO, REG_ZERO}, QUAD_C2));
    pending_words.push_back(compose(C2_JR_MV, {1'b1, REG_ZERO, REG_ZERO}, QUAD_C2));
    pending_words.push_back(compose(C2_JR_MV, {1'b0, REG_ZERO, 5'd9}, QUAD_C2));
    pending_words.push_back(compose(C2_SWSP, 11'h7FF, QUAD_C2));

    // Three random phases: sender-idle heavy receiver stalls, then the reverse,
    // then full rate with the long receiver hold-off.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_armed    = 1'b1;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        pending_words.push_back(random_compressed());
      while (pending_words.size() != 0) @(posedge clk);
    end

    // Let the last transaction go in, wait out every prediction, then drain.
    while (pending_words.size() != 0 || instr_ch.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/rvcx_pkg.sv
src/rvcx_instr_if.sv
src/rvcx_result_if.sv
src/rvcx_in_stage.sv
src/rvcx_decode.sv
src/rvcx_out_stage.sv
src/rv32c_instruction_expander.sv
tb/sv/tb.sv
